>>> hdl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2da_pkg;

   localparam int VALUE_W      = 64;
   localparam int DIGIT_CHAR_W = 6;
   localparam int BCD_W        = 4;

   // '0' is 6'b110000, so a digit code is the BCD digit under 2'b11
   localparam logic [1:0] ASCII_ZERO_HI = 2'b11;

   typedef logic [VALUE_W-1:0]      value_type;
   typedef logic [DIGIT_CHAR_W-1:0] digit_char_type;
   typedef logic [BCD_W-1:0]        bcd_type;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_SHIFT,
      CONV_HOLD
   } conv_state_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_SKIP,
      EMIT_SEND
   } emit_state_type;

   typedef struct packed {
      logic load_in;
      logic shift_conv;
      logic load_emit;
      logic shift_emit;
   } b2da_cmd_type;

   typedef struct packed {
      logic bit_done;
      logic top_zero;
      logic last;
   } b2da_status_type;

endpackage

`default_nettype wire

>>> hdl/b2da_req_if.sv
// ----------------------------------------------------------------------------
// b2da_req_if
// Input channel: one binary value per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface b2da_req_if
   import b2da_pkg::*;
   ();

   logic      valid;
   logic      ready;
   value_type value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);

endinterface

`default_nettype wire

>>> hdl/b2da_rsp_if.sv
// ----------------------------------------------------------------------------
// b2da_rsp_if
// Result channel: one ASCII digit per item, with an end-of-number flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface b2da_rsp_if
   import b2da_pkg::*;
   ();

   logic           valid;
   logic           ready;
   digit_char_type digit_char;
   logic           last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);

endinterface

`default_nettype wire

>>> hdl/b2da_ctrl.sv
// ----------------------------------------------------------------------------
// b2da_ctrl
// Controller: conversion sequencer and digit emitter state machines.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_ctrl
   import b2da_pkg::*;
   (
      input  wire logic            clock,
      input  wire logic            reset,
      input  wire logic            req_valid,
      output logic                 req_ready,
      output logic                 rsp_valid,
      input  wire logic            rsp_ready,
      input  wire b2da_status_type status,
      output b2da_cmd_type         cmd
   );

   conv_state_type conv_state_ff, conv_state_in;
   emit_state_type emit_state_ff, emit_state_in;

   logic emit_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_state_ff <= CONV_IDLE;
         emit_state_ff <= EMIT_IDLE;
      end else begin
         conv_state_ff <= conv_state_in;
         emit_state_ff <= emit_state_in;
      end
   end

   always_comb begin
      conv_state_in  = conv_state_ff;
      emit_state_in  = emit_state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      emit_free      = 1'b0;

      unique case (emit_state_ff)
         EMIT_IDLE: begin
            emit_free = 1'b1;
         end
         EMIT_SKIP: begin
            if (!status.top_zero || status.last) begin
               emit_state_in = EMIT_SEND;
            end else begin
               cmd.shift_emit = 1'b1;
            end
         end
         EMIT_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last) begin
                  emit_free     = 1'b1;
                  emit_state_in = EMIT_IDLE;
               end else begin
                  cmd.shift_emit = 1'b1;
               end
            end
         end
         default: begin
            emit_state_in = EMIT_IDLE;
         end
      endcase

      unique case (conv_state_ff)
         CONV_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in   = 1'b1;
               conv_state_in = CONV_SHIFT;
            end
         end
         CONV_SHIFT: begin
            cmd.shift_conv = 1'b1;
            if (status.bit_done) begin
               conv_state_in = CONV_HOLD;
            end
         end
         CONV_HOLD: begin
            if (emit_free) begin
               cmd.load_emit = 1'b1;
               conv_state_in = CONV_IDLE;
               emit_state_in = EMIT_SKIP;
            end
         end
         default: begin
            conv_state_in = CONV_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/b2da_datapath.sv
// ----------------------------------------------------------------------------
// b2da_datapath
// Double-dabble shift register, BCD accumulator and digit output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b2da_datapath
   import b2da_pkg::*;
   #(
      parameter int VALUE_BITS = 64
   )
   (
      input  wire logic            clock,
      input  wire b2da_cmd_type    cmd,
      input  wire value_type       req_value,
      output b2da_status_type      status,
      output digit_char_type       rsp_digit_char,
      output logic                 rsp_last_digit
   );

   // decimal digits of 2**VALUE_BITS - 1
   localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCDW  = NDIG * BCD_W;
   localparam int BIT_W = $clog2(VALUE_BITS);
   localparam int CNT_W = $clog2(NDIG + 1);

   logic [VALUE_BITS-1:0] value_sr_ff, value_sr_in;
   logic [BIT_W-1:0]      bit_cnt_ff,  bit_cnt_in;
   logic [BCDW-1:0]       bcd_ff,      bcd_in;
   logic [BCDW-1:0]       emit_ff,     emit_in;
   logic [CNT_W-1:0]      emit_cnt_ff, emit_cnt_in;
   logic [BCDW-1:0]       bcd_adj;
   bcd_type               top_digit;

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[i*BCD_W +: BCD_W] >= bcd_type'(5)) begin
            bcd_adj[i*BCD_W +: BCD_W] = bcd_ff[i*BCD_W +: BCD_W] + bcd_type'(3);
         end else begin
            bcd_adj[i*BCD_W +: BCD_W] = bcd_ff[i*BCD_W +: BCD_W];
         end
      end
   end

   always_comb begin
      value_sr_in = value_sr_ff;
      bit_cnt_in  = bit_cnt_ff;
      bcd_in      = bcd_ff;
      if (cmd.load_in) begin
         value_sr_in = req_value[VALUE_BITS-1:0];
         bit_cnt_in  = BIT_W'(VALUE_BITS - 1);
         bcd_in      = '0;
      end else if (cmd.shift_conv) begin
         value_sr_in = {value_sr_ff[VALUE_BITS-2:0], 1'b0};
         bit_cnt_in  = bit_cnt_ff - BIT_W'(1);
         bcd_in      = {bcd_adj[BCDW-2:0], value_sr_ff[VALUE_BITS-1]};
      end
   end

   always_comb begin
      emit_in     = emit_ff;
      emit_cnt_in = emit_cnt_ff;
      if (cmd.load_emit) begin
         emit_in     = bcd_ff;
         emit_cnt_in = CNT_W'(NDIG);
      end else if (cmd.shift_emit) begin
         emit_in     = {emit_ff[BCDW-BCD_W-1:0], {BCD_W{1'b0}}};
         emit_cnt_in = emit_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      value_sr_ff <= value_sr_in;
      bit_cnt_ff  <= bit_cnt_in;
      bcd_ff      <= bcd_in;
      emit_ff     <= emit_in;
      emit_cnt_ff <= emit_cnt_in;
   end

   assign top_digit       = emit_ff[BCDW-1 -: BCD_W];
   assign status.bit_done = (bit_cnt_ff == '0);
   assign status.top_zero = (top_digit == '0);
   assign status.last     = (emit_cnt_ff == CNT_W'(1));
   assign rsp_digit_char  = {ASCII_ZERO_HI, top_digit};
   assign rsp_last_digit  = status.last;

`ifndef SYNTH
   a_load_in_clears: assert property (@(posedge clock)
      cmd.load_in |=> (bcd_ff == '0) && (bit_cnt_ff == BIT_W'(VALUE_BITS - 1)))
      else $error("conversion start did not clear accumulator");

   a_load_emit_copies: assert property (@(posedge clock)
      cmd.load_emit |=> (emit_cnt_ff == CNT_W'(NDIG)) && (emit_ff == $past(bcd_ff)))
      else $error("digit register not loaded from accumulator");

   a_emit_digit_valid: assert property (@(posedge clock)
      cmd.shift_emit |-> (top_digit <= bcd_type'(9)) && (emit_cnt_ff != '0))
      else $error("emitted digit out of range or count exhausted");
`endif

endmodule

`default_nettype wire

>>> hdl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned binary to decimal ASCII text, most significant digit first.
// ----------------------------------------------------------------------------
// req_chan carries one value per item; only its low VALUE_BITS bits count.
// rsp_chan returns one ASCII digit per item, leading zeros dropped, with
// last_digit set on the final digit; zero gives a single '0'.
// A double-dabble shifter takes one input bit per cycle, so conversion
// shifts in all VALUE_BITS bits after acceptance, then hands the digits
// to the output register; a new value is taken after the hand-off while
// the digits of the previous one drain. The first digit appears once the
// leading zeros have been skipped, then one digit per cycle while
// rsp_chan.ready is high. A stalled receiver holds the current
// digit; conversion of the next value goes on, and the hand-off waits until
// the last digit has been taken. Reset is synchronous, returns both state
// machines to idle and drops any item in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii
   import b2da_pkg::*;
   #(
      parameter int VALUE_BITS = 64
   )
   (
      input wire logic clock,
      input wire logic reset,
      b2da_req_if.sink   req_chan,
      b2da_rsp_if.source rsp_chan
   );

   b2da_cmd_type    cmd;
   b2da_status_type status;
   logic            req_ready;
   logic            rsp_valid;
   digit_char_type  rsp_digit_char;
   logic            rsp_last_digit;

   b2da_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   b2da_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .req_value      (req_chan.value),
      .status         (status),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.digit_char = rsp_digit_char;
   assign rsp_chan.last_digit = rsp_last_digit;

endmodule

`default_nettype wire

>>> sim/tb_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_ascii
// Self-checking bench for the binary to decimal ASCII converter. A directed
// table (zero, one-digit and twenty-digit extremes, powers of ten and bit
// patterns) is followed by random values in four flow-control phases. Every
// accepted value is turned into its expected digit string, from the table
// text where a row gives one and else by a local decimal conversion, and each
// returned digit is compared with the oldest one outstanding.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_ascii
   import b2da_pkg::*;
   ;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int        DUT_VALUE_BITS = 64;
   localparam value_type DEC_BASE       = 10;
   localparam int        ASCII_ZERO     = 48;
   localparam int        MAX_DIGITS     = 20;
   localparam int        IDLE_PCT       = 57;
   localparam int        BOTH_PCT       = 38;
   localparam int        ITEMS_PER_PHASE = 70;
   localparam int        DRAIN_CYCLES   = 200;
   localparam int        MAX_PRINTED    = 40;

   typedef struct packed {
      digit_char_type digit_char;
      logic           last_digit;
   } digit_item_type;

   typedef struct {
      value_type value;
      string     text;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   b2da_req_if req_if ();
   b2da_rsp_if rsp_if ();

   digit_item_type pending_digits[$];
   int             mismatches = 0;
   int             idle_pct   = 0;
   int             stall_pct  = 0;

   // empty text: expected digits come from the local conversion
   stim_row_type directed_rows[16] = '{
      '{value_type'(0),                       "0"},
      '{value_type'(1),                       "1"},
      '{value_type'(9),                       "9"},
      '{value_type'(10),                      "10"},
      '{value_type'(99),                      ""},
      '{value_type'(100),                     ""},
      '{value_type'(1023),                    ""},
      '{64'd9999999999999999999,              "9999999999999999999"},
      '{64'd10000000000000000000,             "10000000000000000000"},
      '{64'h8000_0000_0000_0000,              ""},
      '{64'hAAAA_AAAA_AAAA_AAAA,              ""},
      '{64'h5555_5555_5555_5555,              ""},
      '{64'd12345678901234567890,             ""},
      '{64'hFFFF_FFFF_FFFF_FFFF,              "18446744073709551615"},
      '{value_type'(0),                       "0"},
      '{64'hFFFF_FFFF_FFFF_FFFE,              "18446744073709551614"}
   };

   always #5 clock = ~clock;

   binary_to_decimal_ascii #(
      .VALUE_BITS (DUT_VALUE_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   function automatic void append_decimal_digits(input value_type raw);
      bcd_type   rev[MAX_DIGITS];
      value_type rem;
      int        n;
      rem = raw & ({VALUE_W{1'b1}} >> (VALUE_W - DUT_VALUE_BITS));
      n   = 0;
      do begin
         rev[n] = bcd_type'(rem % DEC_BASE);
         rem    = rem / DEC_BASE;
         n++;
      end while (rem != 0 && n < MAX_DIGITS);
      for (int k = 0; k < n; k++) begin
         pending_digits.push_back('{digit_char: digit_char_type'(ASCII_ZERO + rev[n-1-k]),
                                    last_digit: (k == n - 1)});
      end
   endfunction

   function automatic void append_typed_digits(input string text);
      for (int i = 0; i < text.len(); i++) begin
         pending_digits.push_back('{digit_char: digit_char_type'(text[i]),
                                    last_digit: (i == text.len() - 1)});
      end
   endfunction

   function automatic value_type random_value();
      value_type v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v = value_type'($urandom_range(0, 999));
         1: v = v >> $urandom_range(0, 63);
         2: begin
            v = 1;
            repeat ($urandom_range(0, 19)) v = v * DEC_BASE;
            v = v + $urandom_range(0, 2) - 1;
         end
         3: v = {VALUE_W{1'b1}} - $urandom_range(0, 1000);
         default: ;
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_value(input value_type v, input string text);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_if.valid <= 1'b0;
         req_if.value <= {$urandom, $urandom};
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= v;
      do @(posedge clock); while (!req_if.ready);
      if (text.len() == 0) begin
         append_decimal_digits(v);
      end else begin
         append_typed_digits(text);
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      digit_item_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_digits.size() == 0) begin
            report_mismatch($sformatf("digit %0d with no number outstanding",
                                      rsp_if.digit_char));
         end else begin
            want = pending_digits.pop_front();
            if (rsp_if.digit_char !== want.digit_char) begin
               report_mismatch($sformatf("digit_char %0d, expected %0d",
                                         rsp_if.digit_char, want.digit_char));
            end
            if (rsp_if.last_digit !== want.last_digit) begin
               report_mismatch($sformatf("last_digit %0b, expected %0b",
                                         rsp_if.last_digit, want.last_digit));
            end
         end
      end
   end

   initial begin
      req_if.valid <= 1'b0;
      req_if.value <= '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_value(directed_rows[i].value, directed_rows[i].text);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;        stall_pct = 0;        end
            1:       begin idle_pct = IDLE_PCT; stall_pct = 0;        end
            2:       begin idle_pct = 0;        stall_pct = IDLE_PCT; end
            default: begin idle_pct = BOTH_PCT; stall_pct = BOTH_PCT; end
         endcase
         repeat (ITEMS_PER_PHASE) send_value(random_value(), "");
      end
      req_if.valid <= 1'b0;

      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_digits.size() == 0) begin
         $display("tb_binary_to_decimal_ascii passed");
      end else begin
         if (pending_digits.size() != 0) begin
            report_mismatch($sformatf("%0d digits never returned", pending_digits.size()));
         end
         $display("tb_binary_to_decimal_ascii failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_binary_to_decimal_ascii failed");
      $finish;
   end

endmodule
